FILE: sv/mf3_pkg.sv
// Shared constants and types for the 3x3 median filter.
`default_nettype none
package mf3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MIN_DIM      = 3;
    localparam int MAX_HEIGHT   = 1024;

    localparam int ROW_BITS     = 10;
    localparam int COORD_BITS   = 10;
    localparam int OUT_PIX_BITS = 8;
    localparam int WIN_TAPS     = 9;

    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  last;
    } t_meta;

    typedef struct packed {
        logic [OUT_PIX_BITS-1:0] median_value;
        t_meta                   meta;
    } t_res;

endpackage
`default_nettype wire

FILE: sv/mf3_pix_if.sv
// Pixel input channel: valid/ready handshake with pixel and frame start.
`default_nettype none
interface mf3_pix_if #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface
`default_nettype wire

FILE: sv/mf3_res_if.sv
// Result output channel: valid/ready handshake with median and position.
`default_nettype none
interface mf3_res_if ();
    logic                              valid;
    logic                              ready;
    logic [mf3_pkg::OUT_PIX_BITS-1:0]  median_value;
    logic [mf3_pkg::COORD_BITS-1:0]    column;
    logic [mf3_pkg::COORD_BITS-1:0]    row;
    logic                              last;

    modport source (output valid, output median_value, output column, output row,
                    output last, input ready);
    modport sink   (input valid, input median_value, input column, input row,
                    input last, output ready);
endinterface
`default_nettype wire

FILE: sv/mf3_line_store.sv
// Line store memory: one read and one write port, registered read, write forwarding.
`default_nettype none
module mf3_line_store #(
    parameter int DEPTH     = mf3_pkg::MAX_WIDTH_DEF,
    parameter int DATA_BITS = 2 * mf3_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_BITS-1:0]     i_wr_data,
    output logic      [DATA_BITS-1:0]     o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;
    logic [DATA_BITS-1:0] r_fwd_data;
    logic                 r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule
`default_nettype wire

FILE: sv/mf3_median.sv
// Pipelined median-of-nine compare network: column sort, row reduce, final median.
`default_nettype none
module mf3_median #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [PIXEL_BITS-1:0] i_win [mf3_pkg::WIN_TAPS],
    input  wire mf3_pkg::t_meta        i_meta,
    output logic                       o_valid,
    output logic      [PIXEL_BITS-1:0] o_median,
    output mf3_pkg::t_meta             o_meta
);

    function automatic logic [PIXEL_BITS-1:0] min2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] med3(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b,
                                                   input logic [PIXEL_BITS-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [PIXEL_BITS-1:0] n_lo  [3];
    logic [PIXEL_BITS-1:0] n_mid [3];
    logic [PIXEL_BITS-1:0] n_hi  [3];
    logic [PIXEL_BITS-1:0] r_lo  [3];
    logic [PIXEL_BITS-1:0] r_mid [3];
    logic [PIXEL_BITS-1:0] r_hi  [3];
    logic                  r_a_valid;
    mf3_pkg::t_meta        r_a_meta;

    logic [PIXEL_BITS-1:0] r_max_lo;
    logic [PIXEL_BITS-1:0] r_med_mid;
    logic [PIXEL_BITS-1:0] r_min_hi;
    logic                  r_b_valid;
    mf3_pkg::t_meta        r_b_meta;

    // sort each window column (oldest line, middle line, newest line)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lo[k]  = min2(min2(i_win[k], i_win[k+3]), i_win[k+6]);
            n_mid[k] = med3(i_win[k], i_win[k+3], i_win[k+6]);
            n_hi[k]  = max2(max2(i_win[k], i_win[k+3]), i_win[k+6]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo     <= n_lo;
            r_mid    <= n_mid;
            r_hi     <= n_hi;
            r_a_meta <= i_meta;

            r_max_lo  <= max2(max2(r_lo[0], r_lo[1]), r_lo[2]);
            r_med_mid <= med3(r_mid[0], r_mid[1], r_mid[2]);
            r_min_hi  <= min2(min2(r_hi[0], r_hi[1]), r_hi[2]);
            r_b_meta  <= r_a_meta;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_median = med3(r_max_lo, r_med_mid, r_min_hi);
    assign o_meta   = r_b_meta;

endmodule
`default_nettype wire

FILE: sv/mf3_skid.sv
// Two-beat output buffer that decouples the filter pipeline from the result sink.
`default_nettype none
module mf3_skid (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire mf3_pkg::t_res i_data,
    output logic              o_space,
    mf3_res_if.source         o_res
);

    mf3_pkg::t_res r_buf [2];
    logic [1:0]    r_cnt;
    logic          r_wp;
    logic          r_rp;
    logic          pop;
    mf3_pkg::t_res head;

    assign pop     = o_res.valid && o_res.ready;
    assign o_space = (r_cnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    assign head               = r_buf[r_rp];
    assign o_res.valid        = (r_cnt != 2'd0);
    assign o_res.median_value = head.median_value;
    assign o_res.column       = head.meta.column;
    assign o_res.row          = head.meta.row;
    assign o_res.last         = head.meta.last;

endmodule
`default_nettype wire

FILE: sv/median_filter_3x3.sv
// Top level of the 3x3 median filter over a raster pixel stream.
// Takes one pixel per clock in raster order while the output buffer has room, and
// offers each median result through the line store read stage, window register,
// two compare stages and output buffer; border pixels give none. The rate of one
// pixel per cycle is set by the line store, which does one read and one write each
// cycle, and by the compare network, which is split over two register stages. A
// pixel with frame_start set is taken as column 0, row 0. Width and height are
// clamped to [3, MAX_WIDTH] and [3, 1024] and are to be written only while no
// pixel is in flight. Up to two results are buffered at the output for a slow sink.
`default_nettype none
module median_filter_3x3 #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mf3_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [mf3_pkg::CFG_BITS-1:0]       i_cfg_data,
    mf3_pix_if.sink                                 i_pix,
    mf3_res_if.source                               o_res
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int MWB = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (MWB > mf3_pkg::CFG_BITS) ? MWB : mf3_pkg::CFG_BITS;
    localparam int RW  = mf3_pkg::ROW_BITS;
    localparam int HB  = mf3_pkg::CFG_BITS;

    logic [HB-1:0]         r_cfg_width;
    logic [HB-1:0]         r_cfg_height;
    logic [WW-1:0]         w_raw;
    logic [WW-1:0]         w_eff;
    logic [HB-1:0]         h_eff;
    logic [CW-1:0]         last_col;
    logic [RW-1:0]         last_row;

    logic                  res_space;
    logic                  en;
    logic                  accept;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         c0;
    logic [RW-1:0]         r0;
    logic [CW-1:0]         n_col;
    logic [RW-1:0]         n_row;
    logic                  emit0;
    mf3_pkg::t_meta        meta0;

    logic                  r_s1_valid;
    logic [CW-1:0]         r_s1_col;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic                  r_s1_emit;
    mf3_pkg::t_meta        r_s1_meta;
    logic [PIXEL_BITS-1:0] ls_up;
    logic [PIXEL_BITS-1:0] ls_lo;

    logic [PIXEL_BITS-1:0] r_win [mf3_pkg::WIN_TAPS];
    logic [PIXEL_BITS-1:0] n_win [mf3_pkg::WIN_TAPS];
    logic                  r_s2_valid;
    mf3_pkg::t_meta        r_s2_meta;

    logic                  med_valid;
    logic [PIXEL_BITS-1:0] med_value;
    mf3_pkg::t_meta        med_meta;
    mf3_pkg::t_res         res_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= HB'(mf3_pkg::WIDTH_RESET);
            r_cfg_height <= HB'(mf3_pkg::HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mf3_pkg::CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_data;
                mf3_pkg::CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_raw = WW'(r_cfg_width);
        if (w_raw < WW'(mf3_pkg::MIN_DIM)) begin
            w_eff = WW'(mf3_pkg::MIN_DIM);
        end else if (w_raw > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (r_cfg_height < HB'(mf3_pkg::MIN_DIM)) begin
            h_eff = HB'(mf3_pkg::MIN_DIM);
        end else if (r_cfg_height > HB'(mf3_pkg::MAX_HEIGHT)) begin
            h_eff = HB'(mf3_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_height;
        end
        last_col = CW'(w_eff - WW'(1));
        last_row = RW'(h_eff - HB'(1));
    end

    // position of the incoming pixel and of the next one
    assign en           = res_space;
    assign accept       = i_pix.valid && en;
    assign i_pix.ready  = en;

    always_comb begin
        c0    = i_pix.frame_start ? '0 : r_col;
        r0    = i_pix.frame_start ? '0 : r_row;
        emit0 = (c0 >= CW'(2)) && (r0 >= RW'(2)) && (c0 <= last_col) && (r0 <= last_row);
        meta0.column = mf3_pkg::COORD_BITS'(c0 - CW'(1));
        meta0.row    = mf3_pkg::COORD_BITS'(r0 - RW'(1));
        meta0.last   = (c0 == last_col) && (r0 == last_row);
        if (c0 >= last_col) begin
            n_col = '0;
            n_row = (r0 >= last_row) ? '0 : r0 + RW'(1);
        end else begin
            n_col = c0 + CW'(1);
            n_row = r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col  <= c0;
            r_s1_pix  <= i_pix.pixel;
            r_s1_emit <= emit0;
            r_s1_meta <= meta0;
        end
    end

    mf3_line_store #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2 * PIXEL_BITS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (c0),
        .i_wr_en   (en && r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({ls_lo, r_s1_pix}),
        .o_rd_data ({ls_up, ls_lo})
    );

    // window shift: oldest column drops, newest column enters
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = ls_up;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = ls_lo;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mf3_pkg::WIN_TAPS; k++) begin
                r_win[k] <= '0;
            end
            r_s2_valid <= 1'b0;
        end else if (en) begin
            if (r_s1_valid) begin
                r_win <= n_win;
            end
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    mf3_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s2_valid),
        .i_win    (r_win),
        .i_meta   (r_s2_meta),
        .o_valid  (med_valid),
        .o_median (med_value),
        .o_meta   (med_meta)
    );

    assign res_data.median_value = med_value[mf3_pkg::OUT_PIX_BITS-1:0];
    assign res_data.meta         = med_meta;

    mf3_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && med_valid),
        .i_data  (res_data),
        .o_space (res_space),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
